/* sv/imu_tlv_frame_parser_defines.svh */
// Assertion macros used by the frame parser's record walk module.
`ifndef IMU_TLV_FRAME_PARSER_DEFINES_SVH
`define IMU_TLV_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMU_TLV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imu_tlv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IMU_TLV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imu_tlv assertion failed");

`endif

/* sv/imu_tlv_pkg.sv */
package imu_tlv_pkg;

   localparam int PAYLOAD_DEPTH_DEF = 256;

   localparam logic [7:0] HDR_FIRST  = 8'h59;
   localparam logic [7:0] HDR_SECOND = 8'h53;

   localparam logic [7:0] ID_ACCEL     = 8'h10;
   localparam logic [7:0] ID_GYRO      = 8'h20;
   localparam logic [7:0] ID_MAG       = 8'h30;
   localparam logic [7:0] ID_MAG_RAW   = 8'h31;
   localparam logic [7:0] ID_EULER     = 8'h40;
   localparam logic [7:0] ID_QUAT      = 8'h41;
   localparam logic [7:0] ID_TIME_SAMP = 8'h51;
   localparam logic [7:0] ID_TIME_SYNC = 8'h52;
   localparam logic [7:0] ID_POSITION  = 8'h60;
   localparam logic [7:0] ID_VELOCITY  = 8'h70;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_TID0 = 3'd1,
      PH_TID1 = 3'd2,
      PH_LEN  = 3'd3,
      PH_PAY  = 3'd4,
      PH_CKL  = 3'd5,
      PH_CKH  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      W_IDLE = 3'd0,
      W_RD   = 3'd1,
      W_USE  = 3'd2,
      W_REC  = 3'd3,
      W_STAT = 3'd4
   } walk_state_type;

   typedef struct packed {
      logic        valid;
      logic        good;
      logic [15:0] tid;
      logic [7:0]  walk_len;
   } frame_done_type;

   function automatic logic [2:0] words_for_id(input logic [7:0] id);
      logic [2:0] nw;
      unique case (id) inside
         ID_ACCEL, ID_GYRO, ID_MAG, ID_MAG_RAW, ID_EULER, ID_POSITION, ID_VELOCITY: nw = 3'd3;
         ID_QUAT:                    nw = 3'd4;
         ID_TIME_SAMP, ID_TIME_SYNC: nw = 3'd1;
         default:                    nw = 3'd0;
      endcase
      return nw;
   endfunction

endpackage

/* sv/imu_tlv_frame_parser.sv */
// Frame reception takes one request per cycle; after the last check byte the record walk
// starts in the next cycle and the request side stays stalled until the walk ends.
// For a good frame the walk reads a payload byte in W_RD and uses it in W_USE, sends each
// record from W_REC, finds the end of the payload in W_RD unless an overrun stops the walk,
// and ends in W_STAT; a bad frame goes straight there, and a stalled result holds the walk.
// Synchronous reset clears the receiver, walk state and rsp_valid but not the payload RAM.
module imu_tlv_frame_parser #(
   parameter int PAYLOAD_DEPTH = imu_tlv_pkg::PAYLOAD_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_record_id,
   output logic [31:0] rsp_word0,
   output logic [31:0] rsp_word1,
   output logic [31:0] rsp_word2,
   output logic [31:0] rsp_word3,
   output logic [2:0]  rsp_word_count,
   output logic [15:0] rsp_frame_tid,
   output logic        rsp_is_status,
   output logic        rsp_frame_status,
   output logic        rsp_last
);

   import imu_tlv_pkg::*;

   localparam int AW = $clog2(PAYLOAD_DEPTH);

   logic           accept;
   logic           busy;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [7:0]     wr_data;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;
   frame_done_type done;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   imu_tlv_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   imu_tlv_rx #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_rx (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .done    (done)
   );

   imu_tlv_walk #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_walk (
      .clock            (clock),
      .reset            (reset),
      .done             (done),
      .busy             (busy),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_id    (rsp_record_id),
      .rsp_word0        (rsp_word0),
      .rsp_word1        (rsp_word1),
      .rsp_word2        (rsp_word2),
      .rsp_word3        (rsp_word3),
      .rsp_word_count   (rsp_word_count),
      .rsp_frame_tid    (rsp_frame_tid),
      .rsp_is_status    (rsp_is_status),
      .rsp_frame_status (rsp_frame_status),
      .rsp_last         (rsp_last)
   );

endmodule

/* sv/imu_tlv_ram.sv */
module imu_tlv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/imu_tlv_rx.sv */
module imu_tlv_rx #(
   parameter int PAYLOAD_DEPTH = imu_tlv_pkg::PAYLOAD_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [7:0]                       rx_byte,
   output logic                             wr_en,
   output logic [$clog2(PAYLOAD_DEPTH)-1:0] wr_addr,
   output logic [7:0]                       wr_data,
   output imu_tlv_pkg::frame_done_type      done
);

   import imu_tlv_pkg::*;

   localparam int AW = $clog2(PAYLOAD_DEPTH);

   phase_type   phase_ff, phase_in;
   logic [7:0]  prev_ff, prev_in;
   logic [15:0] tid_ff, tid_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  ckl_ff, ckl_in;
   logic [7:0]  sum_a_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         prev_ff  <= '0;
         tid_ff   <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         ckl_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         tid_ff   <= tid_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         ckl_ff   <= ckl_in;
      end
   end

   assign sum_a_next = sum_a_ff + rx_byte;
   assign wr_addr    = idx_ff[AW-1:0];
   assign wr_data    = rx_byte;

   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      tid_in   = tid_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      ckl_in   = ckl_ff;
      wr_en    = 1'b0;
      done     = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_TID0: begin
               tid_in   = {8'h00, rx_byte};
               sum_a_in = sum_a_next;
               sum_b_in = sum_b_ff + sum_a_next;
               phase_in = PH_TID1;
            end
            PH_TID1: begin
               tid_in   = {rx_byte, tid_ff[7:0]};
               sum_a_in = sum_a_next;
               sum_b_in = sum_b_ff + sum_a_next;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in   = rx_byte;
               idx_in   = '0;
               sum_a_in = sum_a_next;
               sum_b_in = sum_b_ff + sum_a_next;
               phase_in = (rx_byte == 8'h00) ? PH_CKL : PH_PAY;
            end
            PH_PAY: begin
               wr_en    = ({1'b0, idx_ff} < 9'(PAYLOAD_DEPTH));
               idx_in   = idx_ff + 8'd1;
               sum_a_in = sum_a_next;
               sum_b_in = sum_b_ff + sum_a_next;
               if (idx_ff + 8'd1 == len_ff) begin
                  phase_in = PH_CKL;
               end
            end
            PH_CKL: begin
               ckl_in   = rx_byte;
               phase_in = PH_CKH;
            end
            PH_CKH: begin
               done.valid    = 1'b1;
               done.good     = (ckl_ff == sum_a_ff) && (rx_byte == sum_b_ff);
               done.tid      = tid_ff;
               done.walk_len = ({1'b0, len_ff} >= 9'(PAYLOAD_DEPTH)) ?
                               8'(PAYLOAD_DEPTH) : len_ff;
               phase_in      = PH_HUNT;
               prev_in       = '0;
            end
            default: begin
               if (prev_ff == HDR_FIRST && rx_byte == HDR_SECOND) begin
                  phase_in = PH_TID0;
                  prev_in  = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
                  tid_in   = '0;
               end else begin
                  phase_in = PH_HUNT;
                  prev_in  = rx_byte;
               end
            end
         endcase
      end
   end

endmodule

/* sv/imu_tlv_walk.sv */
`include "imu_tlv_frame_parser_defines.svh"

module imu_tlv_walk #(
   parameter int PAYLOAD_DEPTH = imu_tlv_pkg::PAYLOAD_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  imu_tlv_pkg::frame_done_type      done,
   output logic                             busy,
   output logic                             rd_en,
   output logic [$clog2(PAYLOAD_DEPTH)-1:0] rd_addr,
   input  logic [7:0]                       rd_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_record_id,
   output logic [31:0]                      rsp_word0,
   output logic [31:0]                      rsp_word1,
   output logic [31:0]                      rsp_word2,
   output logic [31:0]                      rsp_word3,
   output logic [2:0]                       rsp_word_count,
   output logic [15:0]                      rsp_frame_tid,
   output logic                             rsp_is_status,
   output logic                             rsp_frame_status,
   output logic                             rsp_last
);

   import imu_tlv_pkg::*;

   localparam int AW = $clog2(PAYLOAD_DEPTH);

   walk_state_type state_ff, state_in;
   logic [7:0]   pos_ff, pos_in;
   logic [4:0]   off_ff, off_in;
   logic [7:0]   len_ff, len_in;
   logic [15:0]  tid_ff, tid_in;
   logic         good_ff, good_in;
   logic [7:0]   id_ff, id_in;
   logic [2:0]   nw_ff, nw_in;
   logic [127:0] words_ff, words_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_id_ff, rsp_id_in;
   logic [127:0] rsp_words_ff, rsp_words_in;
   logic [2:0]   rsp_count_ff, rsp_count_in;
   logic [15:0]  rsp_tid_ff, rsp_tid_in;
   logic         rsp_stat_flag_ff, rsp_stat_flag_in;
   logic         rsp_status_ff, rsp_status_in;
   logic         rsp_last_ff, rsp_last_in;

   logic         out_free;
   logic         out_take;
   logic         load;
   logic [7:0]   rem;
   logic [2:0]   nw_data;
   logic [4:0]   nw4;
   logic [7:0]   rec_len;
   logic [3:0]   byte_k;
   logic [8:0]   addr_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      off_ff           <= off_in;
      len_ff           <= len_in;
      tid_ff           <= tid_in;
      good_ff          <= good_in;
      id_ff            <= id_in;
      nw_ff            <= nw_in;
      words_ff         <= words_in;
      rsp_id_ff        <= rsp_id_in;
      rsp_words_ff     <= rsp_words_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_tid_ff       <= rsp_tid_in;
      rsp_stat_flag_ff <= rsp_stat_flag_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign busy     = (state_ff != W_IDLE);
   assign out_take = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rem      = len_ff - pos_ff;
   assign nw_data  = words_for_id(rd_data);
   assign nw4      = {nw_ff, 2'b00};
   assign rec_len  = {3'b000, nw4} + 8'd2;
   assign byte_k   = 4'(off_ff - 5'd2);
   assign addr_sum = {1'b0, pos_ff} + {4'b0000, off_ff};
   assign rd_addr  = addr_sum[AW-1:0];

   always_comb begin
      state_in         = state_ff;
      pos_in           = pos_ff;
      off_in           = off_ff;
      len_in           = len_ff;
      tid_in           = tid_ff;
      good_in          = good_ff;
      id_in            = id_ff;
      nw_in            = nw_ff;
      words_in         = words_ff;
      rd_en            = 1'b0;
      load             = 1'b0;
      rsp_id_in        = rsp_id_ff;
      rsp_words_in     = rsp_words_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_tid_in       = rsp_tid_ff;
      rsp_stat_flag_in = rsp_stat_flag_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         W_IDLE: begin
            if (done.valid) begin
               pos_in   = '0;
               off_in   = '0;
               len_in   = done.walk_len;
               tid_in   = done.tid;
               good_in  = done.good;
               state_in = done.good ? W_RD : W_STAT;
            end
         end
         W_RD: begin
            if (off_ff == 5'd0 && pos_ff >= len_ff) begin
               state_in = W_STAT;
            end else begin
               rd_en    = 1'b1;
               state_in = W_USE;
            end
         end
         W_USE: begin
            state_in = W_RD;
            if (off_ff == 5'd0) begin
               id_in = rd_data;
               nw_in = nw_data;
               if (nw_data != 3'd0 && rem >= 8'd2) begin
                  off_in = 5'd1;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end else if (off_ff == 5'd1) begin
               if (rd_data == {3'b000, nw4}) begin
                  if (rec_len > rem) begin
                     state_in = W_STAT;
                  end else begin
                     off_in   = 5'd2;
                     words_in = '0;
                  end
               end else begin
                  pos_in = pos_ff + 8'd1;
                  off_in = 5'd0;
               end
            end else begin
               words_in[{byte_k, 3'b000} +: 8] = rd_data;
               if (off_ff == nw4 + 5'd1) begin
                  state_in = W_REC;
               end else begin
                  off_in = off_ff + 5'd1;
               end
            end
         end
         W_REC: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_id_in        = id_ff;
               rsp_words_in     = words_ff;
               rsp_count_in     = nw_ff;
               rsp_tid_in       = tid_ff;
               rsp_stat_flag_in = 1'b0;
               rsp_status_in    = 1'b0;
               rsp_last_in      = 1'b0;
               pos_in           = pos_ff + rec_len;
               off_in           = '0;
               state_in         = W_RD;
            end
         end
         W_STAT: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_id_in        = '0;
               rsp_words_in     = '0;
               rsp_count_in     = '0;
               rsp_tid_in       = tid_ff;
               rsp_stat_flag_in = 1'b1;
               rsp_status_in    = !good_ff;
               rsp_last_in      = 1'b1;
               state_in         = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (out_take ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_id    = rsp_id_ff;
   assign rsp_word0        = rsp_words_ff[31:0];
   assign rsp_word1        = rsp_words_ff[63:32];
   assign rsp_word2        = rsp_words_ff[95:64];
   assign rsp_word3        = rsp_words_ff[127:96];
   assign rsp_word_count   = rsp_count_ff;
   assign rsp_frame_tid    = rsp_tid_ff;
   assign rsp_is_status    = rsp_stat_flag_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

   `IMU_TLV_ASSERT_NOW(a_done_when_idle, clock, reset, done.valid, state_ff == W_IDLE)
   `IMU_TLV_ASSERT_NEXT(a_read_then_use, clock, reset, rd_en, state_ff == W_USE)
   `IMU_TLV_ASSERT_NOW(a_pos_in_range, clock, reset, state_ff != W_IDLE, pos_ff <= len_ff)
   `IMU_TLV_ASSERT_NOW(a_count_vs_status, clock, reset, rsp_valid_ff,
      rsp_stat_flag_ff == (rsp_count_ff == 3'd0))

endmodule

/* dv/tb_imu_tlv_frame_parser.sv */
`timescale 1ns / 100ps

module tb_imu_tlv_frame_parser;
   import imu_tlv_pkg::*;

   typedef struct packed {
      logic [7:0]  record_id;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic [2:0]  word_count;
      logic [15:0] frame_tid;
      logic        is_status;
      logic        frame_status;
      logic        last;
   } imu_record_type;

   localparam logic [7:0] KNOWN_IDS [10] = '{ID_ACCEL, ID_GYRO, ID_MAG, ID_MAG_RAW, ID_EULER,
                                             ID_QUAT, ID_TIME_SAMP, ID_TIME_SYNC, ID_POSITION,
                                             ID_VELOCITY};
   localparam logic [7:0] ID_UNKNOWN = 8'h50;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_record_id;
   logic [31:0] rsp_word0;
   logic [31:0] rsp_word1;
   logic [31:0] rsp_word2;
   logic [31:0] rsp_word3;
   logic [2:0]  rsp_word_count;
   logic [15:0] rsp_frame_tid;
   logic        rsp_is_status;
   logic        rsp_frame_status;
   logic        rsp_last;

   imu_tlv_frame_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_id    (rsp_record_id),
      .rsp_word0        (rsp_word0),
      .rsp_word1        (rsp_word1),
      .rsp_word2        (rsp_word2),
      .rsp_word3        (rsp_word3),
      .rsp_word_count   (rsp_word_count),
      .rsp_frame_tid    (rsp_frame_tid),
      .rsp_is_status    (rsp_is_status),
      .rsp_frame_status (rsp_frame_status),
      .rsp_last         (rsp_last)
   );

   phase_type   rx_phase = PH_HUNT;
   logic [7:0]  rx_prev = 8'h00;
   logic [15:0] rx_tid = 16'h0000;
   logic [7:0]  rx_length = 8'h00;
   logic [7:0]  rx_index = 8'h00;
   logic [7:0]  rx_sum_a = 8'h00;
   logic [7:0]  rx_sum_b = 8'h00;
   logic [7:0]  rx_check_low = 8'h00;
   logic [7:0]  rx_payload [256];

   imu_record_type expected_records [$];

   int send_gap_max = 7;
   int recv_gap_max = 7;
   int bytes_sent = 0;
   int frames_sent = 0;
   int records_checked = 0;
   int status_checked = 0;
   int bad_status_checked = 0;
   int mismatch_count = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [2:0] record_words(input logic [7:0] id);
      case (id)
         ID_ACCEL, ID_GYRO, ID_MAG, ID_MAG_RAW, ID_EULER, ID_POSITION, ID_VELOCITY: return 3'd3;
         ID_QUAT: return 3'd4;
         ID_TIME_SAMP, ID_TIME_SYNC: return 3'd1;
         default: return 3'd0;
      endcase
   endfunction

   function automatic void add_to_sums(input logic [7:0] value);
      rx_sum_a = rx_sum_a + value;
      rx_sum_b = rx_sum_b + rx_sum_a;
   endfunction

   function automatic string record_text(input imu_record_type r);
      return $sformatf("id=%02h words=%08h %08h %08h %08h count=%0d tid=%04h status=%b/%b last=%b",
                       r.record_id, r.word0, r.word1, r.word2, r.word3, r.word_count,
                       r.frame_tid, r.is_status, r.frame_status, r.last);
   endfunction

   task automatic walk_frame(input logic [7:0] check_high);
      int             pos;
      int             rem;
      int             at;
      logic [2:0]     nw;
      logic [31:0]    w [4];
      logic           good;
      imu_record_type item;
      good = (rx_check_low == rx_sum_a) && (check_high == rx_sum_b);
      pos = 0;
      while (good && pos < rx_length) begin
         rem = rx_length - pos;
         nw = record_words(rx_payload[pos]);
         if (nw != 3'd0 && rem >= 2 && rx_payload[pos + 1] == {nw, 2'b00}) begin
            if (2 + 4 * nw > rem) break;
            for (int j = 0; j < 4; j++) begin
               at = pos + 2 + 4 * j;
               if (j < nw)
                  w[j] = {rx_payload[at + 3], rx_payload[at + 2], rx_payload[at + 1],
                          rx_payload[at]};
               else
                  w[j] = 32'h0;
            end
            item = '0;
            item.record_id = rx_payload[pos];
            item.word0 = w[0];
            item.word1 = w[1];
            item.word2 = w[2];
            item.word3 = w[3];
            item.word_count = nw;
            item.frame_tid = rx_tid;
            expected_records.push_back(item);
            pos += 2 + 4 * nw;
         end else begin
            pos++;
         end
      end
      item = '0;
      item.frame_tid = rx_tid;
      item.is_status = 1'b1;
      item.frame_status = !good;
      item.last = 1'b1;
      expected_records.push_back(item);
      rx_phase = PH_HUNT;
      rx_prev = 8'h00;
   endtask

   task automatic track_rx_byte(input logic [7:0] value);
      case (rx_phase)
         PH_TID0: begin
            rx_tid = {8'h00, value};
            add_to_sums(value);
            rx_phase = PH_TID1;
         end
         PH_TID1: begin
            rx_tid[15:8] = value;
            add_to_sums(value);
            rx_phase = PH_LEN;
         end
         PH_LEN: begin
            rx_length = value;
            rx_index = 8'h00;
            add_to_sums(value);
            rx_phase = (value == 8'h00) ? PH_CKL : PH_PAY;
         end
         PH_PAY: begin
            rx_payload[rx_index] = value;
            add_to_sums(value);
            rx_index = rx_index + 8'h01;
            if (rx_index == rx_length) rx_phase = PH_CKL;
         end
         PH_CKL: begin
            rx_check_low = value;
            rx_phase = PH_CKH;
         end
         PH_CKH: begin
            walk_frame(value);
         end
         default: begin
            if (rx_prev == HDR_FIRST && value == HDR_SECOND) begin
               rx_phase = PH_TID0;
               rx_prev = 8'h00;
               rx_sum_a = 8'h00;
               rx_sum_b = 8'h00;
               rx_tid = 16'h0000;
            end else begin
               rx_phase = PH_HUNT;
               rx_prev = value;
            end
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
      track_rx_byte(value);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [15:0] tid, input logic [7:0] payload [$],
                             input bit corrupt);
      logic [7:0] body [$];
      logic [7:0] sum_a;
      logic [7:0] sum_b;
      body = {tid[7:0], tid[15:8], 8'(payload.size())};
      body = {body, payload};
      sum_a = 8'h00;
      sum_b = 8'h00;
      foreach (body[i]) begin
         sum_a = sum_a + body[i];
         sum_b = sum_b + sum_a;
      end
      if (corrupt) begin
         if ($urandom_range(1, 0) == 1) begin
            sum_a = sum_a ^ 8'(1 << $urandom_range(7, 0));
         end else begin
            sum_b = sum_b ^ 8'(1 << $urandom_range(7, 0));
         end
      end
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      foreach (body[i]) send_byte(body[i]);
      send_byte(sum_a);
      send_byte(sum_b);
      frames_sent++;
   endtask

   task automatic build_payload(ref logic [7:0] p [$], input int target);
      int         kind;
      int         fill;
      logic [7:0] id;
      logic [7:0] len;
      p.delete();
      while (p.size() < target) begin
         kind = $urandom_range(9, 0);
         id = KNOWN_IDS[$urandom_range(9, 0)];
         len = 8'({record_words(id), 2'b00});
         fill = $urandom_range(3, 0);
         if (kind <= 5) begin
            p.push_back(id);
            p.push_back(len);
            repeat (len) p.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom));
         end else if (kind == 6) begin
            p.push_back(id);
            p.push_back(len ^ 8'h04);
         end else if (kind == 7) begin
            p.push_back($urandom_range(1, 0) == 1 ? ID_UNKNOWN : 8'($urandom));
            p.push_back(8'($urandom));
         end else if (kind == 8) begin
            p.push_back(8'($urandom));
         end else begin
            p.push_back(HDR_FIRST);
            p.push_back(HDR_SECOND);
         end
      end
      while (p.size() > target) void'(p.pop_back());
   endtask

   task automatic send_random_frames(input int byte_goal, input bit with_errors);
      logic [7:0] p [$];
      logic [7:0] id;
      while (bytes_sent < byte_goal) begin
         build_payload(p, ($urandom_range(7, 0) == 0) ? $urandom_range(60, 29)
                                                      : $urandom_range(28, 0));
         // A known record cut short at the end of the payload stops the walk.
         if ($urandom_range(5, 0) == 0) begin
            id = KNOWN_IDS[$urandom_range(9, 0)];
            p.push_back(id);
            p.push_back(8'({record_words(id), 2'b00}));
            repeat ($urandom_range(4 * record_words(id) - 1, 0)) p.push_back(8'($urandom));
         end
         send_frame(16'($urandom), p, with_errors && $urandom_range(7, 0) == 0);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_records.size() != 0);
   endtask

   task automatic test_directed_frames();
      logic [7:0] p [$];
      send_gap_max = 7;
      recv_gap_max = 7;
      p.delete();
      send_byte(HDR_FIRST);
      send_frame(16'hFFFF, p, 1'b0);
      send_frame(16'h0000, p, 1'b1);
      p = {ID_TIME_SAMP, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
           ID_TIME_SYNC, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, ID_UNKNOWN};
      send_frame(16'h5359, p, 1'b0);
   endtask

   task automatic test_random_frames(input int byte_goal);
      send_gap_max = 7;
      recv_gap_max = 7;
      send_random_frames(byte_goal, 1'b1);
   endtask

   task automatic test_back_to_back(input int byte_goal);
      send_gap_max = 0;
      recv_gap_max = 0;
      send_random_frames(byte_goal, 1'b0);
   endtask

   task automatic test_long_payload();
      logic [7:0] p [$];
      wait_for_drain();
      send_gap_max = 3;
      recv_gap_max = 7;
      build_payload(p, 255);
      send_frame(16'($urandom), p, 1'b0);
   endtask

   task automatic test_noise_and_broken_frames(input int byte_goal);
      logic [7:0] p [$];
      logic [7:0] noise;
      int         kind;
      int         len;
      send_gap_max = 7;
      recv_gap_max = 7;
      while (bytes_sent < byte_goal) begin
         kind = $urandom_range(4, 0);
         if (kind == 0) begin
            repeat ($urandom_range(6, 1)) begin
               case ($urandom_range(2, 0))
                  0: noise = HDR_FIRST;
                  1: noise = HDR_SECOND;
                  default: noise = 8'($urandom);
               endcase
               send_byte(noise);
            end
         end else if (kind == 1) begin
            // A frame cut short soaks up the bytes that follow it.
            len = $urandom_range(12, 0);
            send_byte(HDR_FIRST);
            send_byte(HDR_SECOND);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
            send_byte(8'(len));
            repeat ($urandom_range(len, 0)) send_byte(8'($urandom));
         end else begin
            build_payload(p, $urandom_range(20, 0));
            send_frame(16'($urandom), p, kind == 4);
         end
      end
   endtask

   task automatic check_result();
      imu_record_type got;
      imu_record_type want;
      string          diffs;
      got = {rsp_record_id, rsp_word0, rsp_word1, rsp_word2, rsp_word3, rsp_word_count,
             rsp_frame_tid, rsp_is_status, rsp_frame_status, rsp_last};
      if (got.is_status === 1'b1) begin
         status_checked++;
         if (got.frame_status === 1'b1) bad_status_checked++;
      end else begin
         records_checked++;
      end
      if (expected_records.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: unexpected result: %s", $time, record_text(got));
      end else begin
         want = expected_records.pop_front();
         diffs = "";
         if (got.record_id !== want.record_id) diffs = {diffs, " record_id"};
         if (got.word0 !== want.word0) diffs = {diffs, " word0"};
         if (got.word1 !== want.word1) diffs = {diffs, " word1"};
         if (got.word2 !== want.word2) diffs = {diffs, " word2"};
         if (got.word3 !== want.word3) diffs = {diffs, " word3"};
         if (got.word_count !== want.word_count) diffs = {diffs, " word_count"};
         if (got.frame_tid !== want.frame_tid) diffs = {diffs, " frame_tid"};
         if (got.is_status !== want.is_status) diffs = {diffs, " is_status"};
         if (got.frame_status !== want.frame_status) diffs = {diffs, " frame_status"};
         if (got.last !== want.last) diffs = {diffs, " last"};
         if (diffs != "") begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: mismatch in%s", $time, diffs);
               $display("   expected %s", record_text(want));
               $display("   actual   %s", record_text(got));
            end
         end
      end
   endtask

   initial begin
      int wait_cycles;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         wait_cycles = $urandom_range(recv_gap_max, 0);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_result();
      end
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int drain_cycles;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_random_frames(bytes_sent + 35);
      test_back_to_back(bytes_sent + 35);
      test_long_payload();
      test_noise_and_broken_frames(bytes_sent + 25);

      req_valid <= 1'b0;
      drain_cycles = 0;
      while (expected_records.size() != 0 && drain_cycles < 50000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (100) @(posedge clock);
      if (expected_records.size() != 0) begin
         $display("%0d expected results never arrived.", expected_records.size());
         mismatch_count += expected_records.size();
      end

      $display("Sent %0d bytes in %0d complete frames plus noise and cut-short frames.",
               bytes_sent, frames_sent);
      $display("Checked %0d records and %0d frame status items, %0d of them check errors.",
               records_checked, status_checked, bad_status_checked);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
